FILE: rtl/acp_pkg.sv
package acp_pkg;

    typedef enum logic [2:0] {
        REQ_RESERVE  = 3'd0,
        REQ_RELEASE  = 3'd1,
        REQ_SET_LEN  = 3'd2,
        REQ_SET_FMT  = 3'd3,
        REQ_OUTPUT   = 3'd4,
        REQ_REST_LEN = 3'd5
    } req_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_DIV,
        ST_UPDATE,
        ST_PUSH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
        logic update;
        logic push;
    } acp_cmd_t;

    typedef struct packed {
        logic needs_div;
        logic div_busy;
        logic out_free;
    } acp_sts_t;

    localparam int unsigned US_PER_S = 1000000;
    localparam int unsigned RATE_HZ  = 44100;
    localparam int unsigned COMMON_F = 100;

    // Frames to microseconds: frames * FRAME_NUM / FRAME_DEN.
    localparam int unsigned FRAME_NUM = US_PER_S / COMMON_F;
    localparam int unsigned FRAME_DEN = RATE_HZ / COMMON_F;
    // Microseconds to frames: us * REST_NUM / REST_DEN.
    localparam int unsigned REST_NUM = RATE_HZ / COMMON_F;
    localparam int unsigned REST_DEN = US_PER_S / COMMON_F;

    localparam int TIME_W      = 48;
    localparam int FRAME_W     = 16;
    localparam int SCALED_W    = 30;
    localparam int ADD_W       = 21;
    localparam int DIVIDEND_W  = 64;
    localparam int DIVISOR_W   = 14;
    localparam int DIGIT_W     = 16;
    localparam int NUM_DIGITS  = DIVIDEND_W / DIGIT_W;
    localparam int DIG_CNT_W   = $clog2(NUM_DIGITS);
    localparam int PART_W      = DIVISOR_W + DIGIT_W;
    localparam int RECIP_W     = 31;
    localparam int PROD_W      = PART_W + RECIP_W;
    localparam int QUOT_W      = 32;
    localparam int MONO_BIT    = 4;

    // For x below 2**PART_W, (x * RECIP) >> SHIFT equals x / d exactly when
    // SHIFT is PART_W plus ceil(log2(d)) and RECIP is ceil(2**SHIFT / d).
    localparam int FRAME_SHIFT = PART_W + $clog2(FRAME_DEN);
    localparam int REST_SHIFT  = PART_W + $clog2(REST_DEN);
    localparam longint unsigned FRAME_RECIP =
        ((64'd1 << FRAME_SHIFT) + FRAME_DEN - 1) / FRAME_DEN;
    localparam longint unsigned REST_RECIP =
        ((64'd1 << REST_SHIFT) + REST_DEN - 1) / REST_DEN;

endpackage

FILE: rtl/acp_div.sv
module acp_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                sel_rest,
    input  logic [acp_pkg::DIVIDEND_W-1:0]      dividend,
    output logic                                busy,
    output logic [acp_pkg::QUOT_W-1:0]          quotient
);
    import acp_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  phase_reg, phase_next;
    logic                  sel_reg, sel_next;
    logic [DIG_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [PART_W-1:0]     part;
    logic [RECIP_W-1:0]    recip;
    logic [DIVISOR_W-1:0]  dsr;
    logic [DIGIT_W-1:0]    digit_q;
    logic [PART_W-1:0]     back;

    // Long division by a constant, one 16-bit digit at a time from the top.
    // The partial dividend (remainder and next digit) stays below 2**PART_W,
    // so the reciprocal product gives the exact quotient digit. The first phase
    // of a digit forms the product, the second takes the remainder.
    assign part    = {rem_reg, dvd_reg[DIVIDEND_W-1 -: DIGIT_W]};
    assign recip   = sel_reg ? RECIP_W'(REST_RECIP) : RECIP_W'(FRAME_RECIP);
    assign dsr     = sel_reg ? DIVISOR_W'(REST_DEN) : DIVISOR_W'(FRAME_DEN);
    assign digit_q = sel_reg ? prod_reg[REST_SHIFT +: DIGIT_W]
                             : prod_reg[FRAME_SHIFT +: DIGIT_W];
    assign back    = PART_W'(digit_q) * PART_W'(dsr);

    always_comb
    begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        prod_next  = prod_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            phase_next = 1'b0;
            sel_next   = sel_rest;
            cnt_next   = DIG_CNT_W'(NUM_DIGITS - 1);
            dvd_next   = dividend;
            rem_next   = '0;
            quot_next  = '0;
        end
        else if (busy_reg)
        begin
            phase_next = !phase_reg;
            if (!phase_reg)
            begin
                prod_next = PROD_W'(part) * PROD_W'(recip);
            end
            else
            begin
                rem_next  = DIVISOR_W'(part - back);
                quot_next = {quot_reg[QUOT_W-DIGIT_W-1:0], digit_q};
                dvd_next  = dvd_reg << DIGIT_W;
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg  <= sel_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        prod_reg <= prod_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

FILE: rtl/acp_dp.sv
module acp_dp #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  acp_pkg::acp_cmd_t               cmd,
    output acp_pkg::acp_sts_t               sts,
    input  logic [2:0]                      req_type,
    input  logic signed [7:0]               channel_number,
    input  logic [15:0]                     sample_count,
    input  logic [15:0]                     format_word,
    input  logic [47:0]                     now_us,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic                            status,
    output logic [31:0]                     reply_value,
    output logic [31:0]                     wait_us,
    output logic                            is_mono
);
    import acp_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Captured transaction
    logic [2:0]         req_reg;
    logic signed [7:0]  chan_reg;
    logic [15:0]        count_reg;
    logic [15:0]        fmt_reg;
    logic [TIME_W-1:0]  now_reg;

    // Channel table
    logic               flag_reg   [NUM_CHANNELS];
    logic [FRAME_W-1:0] frames_reg [NUM_CHANNELS];
    logic [15:0]        format_reg [NUM_CHANNELS];
    logic [TIME_W-1:0]  qend_reg   [NUM_CHANNELS];

    // Intermediate values between phases
    logic [TIME_W-1:0]  end_stg_reg, end_stg_next;
    logic [TIME_W-1:0]  rem_stg_reg, rem_stg_next;
    logic [FRAME_W-1:0] frames_stg_reg, frames_stg_next;

    // Staged result
    logic               res_status_reg, res_status_next;
    logic [31:0]        res_value_reg, res_value_next;
    logic [31:0]        res_wait_reg, res_wait_next;
    logic               res_mono_reg, res_mono_next;

    // Output register
    logic               rsp_valid_reg;
    logic               status_reg;
    logic [31:0]        reply_value_reg;
    logic [31:0]        wait_us_reg;
    logic               is_mono_reg;

    logic               chan_ok;
    logic [IDX_W-1:0]   idx;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic               rsv_ok;
    logic [IDX_W-1:0]   rsv_idx;
    logic [TIME_W-1:0]  qend_rd;
    logic [TIME_W-1:0]  raised;
    logic [TIME_W-1:0]  wait_full;
    logic [TIME_W-1:0]  rem_now;
    logic [SCALED_W-1:0]   frame_scaled;
    logic [DIVIDEND_W-1:0] rem_scaled;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic                  div_sel_rest;
    logic [QUOT_W-1:0]     div_quot;
    logic                  div_busy;
    logic [TIME_W:0]       end_sum;

    logic               wr_flag_en;
    logic               wr_flag_val;
    logic               wr_frames_en;
    logic               wr_format_en;
    logic               wr_qend_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [TIME_W-1:0]  wr_qend_val;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg   <= req_type;
            chan_reg  <= channel_number;
            count_reg <= sample_count;
            fmt_reg   <= format_word;
            now_reg   <= now_us;
        end
    end

    assign chan_ok = !chan_reg[7] && ($unsigned(chan_reg) < 8'(NUM_CHANNELS));
    // Out-of-range channels read entry zero; their results never use it.
    assign idx     = chan_ok ? chan_reg[IDX_W-1:0] : '0;
    assign qend_rd = qend_reg[idx];

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--)
        begin
            if (!flag_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (chan_reg[7])
        begin
            rsv_ok  = free_found;
            rsv_idx = free_idx;
        end
        else
        begin
            rsv_ok  = chan_ok && !flag_reg[idx];
            rsv_idx = idx;
        end
    end

    assign raised    = (qend_rd < now_reg) ? now_reg : qend_rd;
    assign wait_full = raised - now_reg;
    assign rem_now   = (qend_rd > now_reg) ? (qend_rd - now_reg) : '0;

    assign frame_scaled = SCALED_W'(frames_stg_reg) * SCALED_W'(FRAME_NUM);
    assign rem_scaled   = DIVIDEND_W'(rem_stg_reg) * DIVIDEND_W'(REST_NUM);
    assign div_dividend = (req_reg == REQ_OUTPUT) ? DIVIDEND_W'(frame_scaled) : rem_scaled;
    assign div_sel_rest = (req_reg != REQ_OUTPUT);

    acp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .sel_rest (div_sel_rest),
        .dividend (div_dividend),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    assign end_sum = {1'b0, end_stg_reg} + (TIME_W + 1)'(div_quot[ADD_W-1:0]);

    always_comb
    begin
        wr_flag_en      = 1'b0;
        wr_flag_val     = 1'b0;
        wr_frames_en    = 1'b0;
        wr_format_en    = 1'b0;
        wr_qend_en      = 1'b0;
        wr_idx          = idx;
        wr_qend_val     = '0;
        end_stg_next    = end_stg_reg;
        rem_stg_next    = rem_stg_reg;
        frames_stg_next = frames_stg_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_wait_next   = res_wait_reg;
        res_mono_next   = res_mono_reg;
        if (cmd.exec)
        begin
            res_status_next = 1'b0;
            res_value_next  = '0;
            res_wait_next   = '0;
            res_mono_next   = 1'b0;
            unique case (req_reg)
                REQ_RESERVE:
                begin
                    res_status_next = !rsv_ok;
                    if (rsv_ok)
                    begin
                        wr_idx         = rsv_idx;
                        wr_flag_en     = 1'b1;
                        wr_flag_val    = 1'b1;
                        wr_frames_en   = 1'b1;
                        wr_format_en   = 1'b1;
                        wr_qend_en     = 1'b1;
                        res_value_next = 32'(rsv_idx);
                    end
                end
                REQ_RELEASE:
                begin
                    wr_flag_en = chan_ok;
                end
                REQ_SET_LEN:
                begin
                    wr_frames_en = chan_ok;
                end
                REQ_SET_FMT:
                begin
                    wr_format_en = chan_ok;
                end
                REQ_OUTPUT:
                begin
                    res_status_next = !chan_ok;
                    if (chan_ok)
                    begin
                        frames_stg_next = frames_reg[idx];
                        end_stg_next    = raised;
                        res_value_next  = 32'(frames_reg[idx]);
                        res_wait_next   = (|wait_full[TIME_W-1:32]) ? '1 : wait_full[31:0];
                        res_mono_next   = format_reg[idx][MONO_BIT];
                    end
                end
                REQ_REST_LEN:
                begin
                    res_status_next = !chan_ok;
                    rem_stg_next    = rem_now;
                end
                default:
                begin
                    res_status_next = 1'b1;
                end
            endcase
        end
        else if (cmd.update)
        begin
            if (req_reg == REQ_OUTPUT)
            begin
                wr_qend_en  = 1'b1;
                wr_qend_val = end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
            end
            else
            begin
                res_value_next = div_quot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                flag_reg[i]   <= 1'b0;
                frames_reg[i] <= '0;
                format_reg[i] <= '0;
                qend_reg[i]   <= '0;
            end
        end
        else
        begin
            if (wr_flag_en)
            begin
                flag_reg[wr_idx] <= wr_flag_val;
            end
            if (wr_frames_en)
            begin
                frames_reg[wr_idx] <= count_reg;
            end
            if (wr_format_en)
            begin
                format_reg[wr_idx] <= fmt_reg;
            end
            if (wr_qend_en)
            begin
                qend_reg[wr_idx] <= wr_qend_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        end_stg_reg    <= end_stg_next;
        rem_stg_reg    <= rem_stg_next;
        frames_stg_reg <= frames_stg_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_wait_reg   <= res_wait_next;
        res_mono_reg   <= res_mono_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            status_reg      <= res_status_reg;
            reply_value_reg <= res_value_reg;
            wait_us_reg     <= res_wait_reg;
            is_mono_reg     <= res_mono_reg;
        end
    end

    assign sts.needs_div = chan_ok && (req_reg == REQ_OUTPUT || req_reg == REQ_REST_LEN);
    assign sts.div_busy  = div_busy;
    assign sts.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign reply_value = reply_value_reg;
    assign wait_us     = wait_us_reg;
    assign is_mono     = is_mono_reg;

    a_load_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> div_busy)
        else $error("divider did not start after load");

    a_update_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (sts.needs_div && !div_busy))
        else $error("update issued while divider busy or not needed");

    a_push_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> sts.out_free ##1 rsp_valid_reg)
        else $error("result pushed into an occupied output register");

endmodule

FILE: rtl/acp_ctrl.sv
module acp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  acp_pkg::acp_sts_t   sts,
    output acp_pkg::acp_cmd_t   cmd
);
    import acp_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.needs_div ? ST_LOAD : ST_PUSH;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/audio_channel_pacer.sv
// Audio channel pacer: a table of output channels that paces driver requests
// in virtual time. A request transaction (req_valid/req_stall) carries the
// request code, channel, frame count, format and the current time; each one
// produces exactly one response transaction (rsp_valid/rsp_stall) with the
// status, reply value, wait time and mono flag.
// Requests are handled one at a time. Reserve, release, set length, set
// format and rejected requests go from the execute state straight to the
// push state. Output and rest-length requests pass through a divider by a
// constant that forms one 16-bit quotient digit at a time by reciprocal
// multiplication, four digits in all, before the response is pushed; the
// next request is taken only after the response has been pushed.
// Reset clears every channel entry (not reserved, zero length, zero format,
// queue end at time zero) and empties the response register.
// A finished response waits in the output register while the receiver
// stalls; the block still takes and works on the next request and holds
// its result back until the output register is free.
module audio_channel_pacer #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [2:0]          req_type,
    input  logic signed [7:0]   channel_number,
    input  logic [15:0]         sample_count,
    input  logic [15:0]         format_word,
    input  logic [47:0]         now_us,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic                status,
    output logic [31:0]         reply_value,
    output logic [31:0]         wait_us,
    output logic                is_mono
);
    import acp_pkg::*;

    acp_cmd_t cmd;
    acp_sts_t sts;

    acp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    acp_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (req_type),
        .channel_number (channel_number),
        .sample_count   (sample_count),
        .format_word    (format_word),
        .now_us         (now_us),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .status         (status),
        .reply_value    (reply_value),
        .wait_us        (wait_us),
        .is_mono        (is_mono)
    );

endmodule
